// ===== hw/rtl/mfl_pkg.sv =====
// mfl_pkg: shared constants and types for the level-graph max flow engine
// field widths, operation codes and the node store write-enable group
// no dependencies
package mfl_pkg;

    // fixed field widths of the item, result and configuration channels
    localparam int OP_W    = 2;
    localparam int NODE_W  = 6;
    localparam int AMT_W   = 16;
    localparam int FLOW_W  = 22;
    localparam int INNER_W = 6;

    // inner node count after reset
    localparam logic [INNER_W-1:0] INNER_RESET = 6'd62;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd2;

    // write enables of the per-node store
    typedef struct packed {
        logic level;
        logic arc;
        logic queue;
        logic stack;
    } t_node_we;

endpackage

// ===== hw/rtl/mfl_cap_mem.sv =====
// mfl_cap_mem: residual capacity matrix, one write port and one read port
// read data registered
// no dependencies
module mfl_cap_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mfl_node_mem.sv =====
// mfl_node_mem: per-node store of the search (level, next arc, bfs queue, path stack)
// each array has one write and one registered read port
// depends on mfl_pkg
module mfl_node_mem #(
    parameter int NODES    = 64,
    parameter int NB       = 6,
    parameter int CAP_BITS = 16
) (
    input  logic                  i_clk,
    input  mfl_pkg::t_node_we     i_we,
    input  logic [NB-1:0]         i_node_waddr,
    input  logic [NB:0]           i_lvl_wdata,
    input  logic [NB:0]           i_arc_wdata,
    input  logic [NB-1:0]         i_lvl_raddr,
    input  logic [NB-1:0]         i_arc_raddr,
    output logic [NB:0]           o_lvl_rdata,
    output logic [NB:0]           o_arc_rdata,
    input  logic [NB-1:0]         i_q_waddr,
    input  logic [2*NB-1:0]       i_q_wdata,
    input  logic [NB-1:0]         i_q_raddr,
    output logic [2*NB-1:0]       o_q_rdata,
    input  logic [NB-1:0]         i_stk_waddr,
    input  logic [NB+CAP_BITS-1:0] i_stk_wdata,
    input  logic [NB-1:0]         i_stk_raddr,
    output logic [NB+CAP_BITS-1:0] o_stk_rdata
);
    import mfl_pkg::*;

    logic [NB:0]            r_lvl_mem [NODES];
    logic [NB:0]            r_arc_mem [NODES];
    logic [2*NB-1:0]        r_q_mem   [NODES];
    logic [NB+CAP_BITS-1:0] r_stk_mem [NODES];

    logic [NB:0]            r_lvl_rdata;
    logic [NB:0]            r_arc_rdata;
    logic [2*NB-1:0]        r_q_rdata;
    logic [NB+CAP_BITS-1:0] r_stk_rdata;

    // write ports
    always_ff @(posedge i_clk) begin
        if (i_we.level) begin
            r_lvl_mem[i_node_waddr] <= i_lvl_wdata;
        end
        if (i_we.arc) begin
            r_arc_mem[i_node_waddr] <= i_arc_wdata;
        end
        if (i_we.queue) begin
            r_q_mem[i_q_waddr] <= i_q_wdata;
        end
        if (i_we.stack) begin
            r_stk_mem[i_stk_waddr] <= i_stk_wdata;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        r_lvl_rdata <= r_lvl_mem[i_lvl_raddr];
        r_arc_rdata <= r_arc_mem[i_arc_raddr];
        r_q_rdata   <= r_q_mem[i_q_raddr];
        r_stk_rdata <= r_stk_mem[i_stk_raddr];
    end

    assign o_lvl_rdata = r_lvl_rdata;
    assign o_arc_rdata = r_arc_rdata;
    assign o_q_rdata   = r_q_rdata;
    assign o_stk_rdata = r_stk_rdata;

endmodule

// ===== hw/rtl/max_flow_level_graph.sv =====
// Max flow engine (Dinic) over a dense residual capacity matrix held in one
// single-port-read, single-port-write memory. After reset, and after every clear
// item, the matrix is swept to zero one entry per cycle, all MAX_NODES*MAX_NODES
// entries (4096 at the defaults), during which no item is taken. An add item reads
// the entry while idle, then writes back the saturating sum. A run item is data
// dependent: each phase resets the nodes up to the sink, then runs a breadth-first
// pass over each queued node and each (queued node, candidate node) pair, then a
// depth-first walk over walk starts, arcs tried, steps down, dead ends with their
// retreats and path edges updated on a push; residual reads all go through the
// one read port of that memory. The total flow leaves through an output register,
// so a new item is taken while the result still waits for its transfer.
// depends on mfl_pkg, mfl_cap_mem, mfl_node_mem
module max_flow_level_graph #(
    parameter int MAX_NODES = 64,
    parameter int CAP_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mfl_pkg::OP_W-1:0]      i_operation,
    input  logic [mfl_pkg::NODE_W-1:0]    i_from_node,
    input  logic [mfl_pkg::NODE_W-1:0]    i_to_node,
    input  logic [mfl_pkg::AMT_W-1:0]     i_amount,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mfl_pkg::FLOW_W-1:0]    o_total_flow,
    input  logic                          i_cfg_we,
    input  logic [mfl_pkg::INNER_W-1:0]   i_cfg_wdata
);
    import mfl_pkg::*;

    localparam int NB    = $clog2(MAX_NODES);
    localparam int AW    = $clog2(MAX_NODES * MAX_NODES);
    localparam int SW    = ((CAP_BITS > AMT_W) ? CAP_BITS : AMT_W) + 1;
    localparam int FW    = ((CAP_BITS > FLOW_W) ? CAP_BITS : FLOW_W) + 1;
    localparam logic [CAP_BITS-1:0] CAP_MAX  = '1;
    localparam logic [FLOW_W-1:0]   FLOW_MAX = '1;
    localparam logic [AW-1:0]       LAST_ADDR = AW'(MAX_NODES * MAX_NODES - 1);
    localparam logic [8:0]          SINK_LIM  = 9'(MAX_NODES - 2);
    localparam logic [8:0]          NODE_LIM  = 9'(MAX_NODES);

    typedef enum logic [18:0] {
        S_CLEAR   = 19'b0000000000000000001,
        S_IDLE    = 19'b0000000000000000010,
        S_ADD     = 19'b0000000000000000100,
        S_SWEEP   = 19'b0000000000000001000,
        S_B_POP   = 19'b0000000000000010000,
        S_B_NODE  = 19'b0000000000000100000,
        S_B_RD    = 19'b0000000000001000000,
        S_B_EV    = 19'b0000000000010000000,
        S_D_START = 19'b0000000000100000000,
        S_D_ARC   = 19'b0000000001000000000,
        S_D_RD    = 19'b0000000010000000000,
        S_D_EV    = 19'b0000000100000000000,
        S_P_STK   = 19'b0000001000000000000,
        S_P_ARC   = 19'b0000010000000000000,
        S_U_STK   = 19'b0000100000000000000,
        S_U_NODE  = 19'b0001000000000000000,
        S_U_FWD   = 19'b0010000000000000000,
        S_U_REV   = 19'b0100000000000000000,
        S_FINISH  = 19'b1000000000000000000
    } t_state;

    // matrix address of entry [a][b]
    function automatic logic [AW-1:0] addr_of(input logic [NB-1:0] a, input logic [NB-1:0] b);
        addr_of = AW'(a) * AW'(MAX_NODES) + AW'(b);
    endfunction

    t_state                r_state, n_state;
    logic [AW-1:0]         r_addr, n_addr;
    logic [INNER_W-1:0]    r_inner;
    logic                  r_out_valid, n_out_valid;
    logic [FLOW_W-1:0]     r_out_flow;
    logic [AMT_W-1:0]      r_amount, n_amount;
    logic [NB-1:0]         r_i, n_i;
    logic [NB:0]           r_head, n_head;
    logic [NB:0]           r_tail, n_tail;
    logic [NB-1:0]         r_u, n_u;
    logic [NB-1:0]         r_lu, n_lu;
    logic                  r_found, n_found;
    logic [NB-1:0]         r_x, n_x;
    logic [NB-1:0]         r_d, n_d;
    logic [CAP_BITS-1:0]   r_low, n_low;
    logic [NB:0]           r_arc, n_arc;
    logic [CAP_BITS-1:0]   r_got, n_got;
    logic [NB-1:0]         r_k, n_k;
    logic [NB-1:0]         r_child, n_child;
    logic [FLOW_W-1:0]     r_flow, n_flow;
    logic                  load_out;

    // memory control
    logic                  cap_we;
    logic [AW-1:0]         cap_waddr, cap_raddr;
    logic [CAP_BITS-1:0]   cap_wdata, cap_rdata;
    t_node_we              node_we;
    logic [NB-1:0]         node_waddr, lvl_raddr, arc_raddr;
    logic [NB:0]           lvl_wdata, arc_wdata, lvl_rdata, arc_rdata;
    logic [NB-1:0]         q_waddr, q_raddr;
    logic [2*NB-1:0]       q_wdata, q_rdata;
    logic [NB-1:0]         stk_waddr, stk_raddr;
    logic [NB+CAP_BITS-1:0] stk_wdata, stk_rdata;

    // derived values
    logic [8:0]            inner9;
    logic [NB-1:0]         sink;
    logic                  in_range;
    logic [SW-1:0]         add_sum, rev_sum;
    logic [FW-1:0]         flow_sum;
    logic [CAP_BITS-1:0]   new_low;
    logic [NB-1:0]         stk_node;
    logic [CAP_BITS-1:0]   stk_low;

    mfl_cap_mem #(
        .DEPTH (MAX_NODES * MAX_NODES),
        .AW    (AW),
        .DW    (CAP_BITS)
    ) u_cap_mem (
        .i_clk   (i_clk),
        .i_we    (cap_we),
        .i_waddr (cap_waddr),
        .i_wdata (cap_wdata),
        .i_raddr (cap_raddr),
        .o_rdata (cap_rdata)
    );

    mfl_node_mem #(
        .NODES    (MAX_NODES),
        .NB       (NB),
        .CAP_BITS (CAP_BITS)
    ) u_node_mem (
        .i_clk        (i_clk),
        .i_we         (node_we),
        .i_node_waddr (node_waddr),
        .i_lvl_wdata  (lvl_wdata),
        .i_arc_wdata  (arc_wdata),
        .i_lvl_raddr  (lvl_raddr),
        .i_arc_raddr  (arc_raddr),
        .o_lvl_rdata  (lvl_rdata),
        .o_arc_rdata  (arc_rdata),
        .i_q_waddr    (q_waddr),
        .i_q_wdata    (q_wdata),
        .i_q_raddr    (q_raddr),
        .o_q_rdata    (q_rdata),
        .i_stk_waddr  (stk_waddr),
        .i_stk_wdata  (stk_wdata),
        .i_stk_raddr  (stk_raddr),
        .o_stk_rdata  (stk_rdata)
    );

    // sink node, clamped to the last node
    assign inner9 = 9'(r_inner);
    assign sink   = NB'(((inner9 > SINK_LIM) ? SINK_LIM : inner9) + 9'd1);

    assign in_range = (9'(i_from_node) < NODE_LIM) && (9'(i_to_node) < NODE_LIM);

    // saturating adds and path bottleneck
    assign add_sum  = SW'(cap_rdata) + SW'(r_amount);
    assign rev_sum  = SW'(cap_rdata) + SW'(r_got);
    assign flow_sum = FW'(r_flow) + FW'(r_got);
    assign new_low  = (cap_rdata < r_low) ? cap_rdata : r_low;
    assign stk_node = stk_rdata[NB+CAP_BITS-1:CAP_BITS];
    assign stk_low  = stk_rdata[CAP_BITS-1:0];

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_total_flow = r_out_flow;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_amount   = r_amount;
        n_i        = r_i;
        n_head     = r_head;
        n_tail     = r_tail;
        n_u        = r_u;
        n_lu       = r_lu;
        n_found    = r_found;
        n_x        = r_x;
        n_d        = r_d;
        n_low      = r_low;
        n_arc      = r_arc;
        n_got      = r_got;
        n_k        = r_k;
        n_child    = r_child;
        n_flow     = r_flow;
        load_out   = 1'b0;
        cap_we     = 1'b0;
        cap_waddr  = r_addr;
        cap_wdata  = '0;
        cap_raddr  = addr_of(r_x, r_child);
        node_we    = '0;
        node_waddr = r_x;
        lvl_wdata  = '0;
        arc_wdata  = '0;
        lvl_raddr  = r_i;
        arc_raddr  = r_x;
        q_waddr    = NB'(r_tail);
        q_wdata    = '0;
        q_raddr    = NB'(r_head);
        stk_waddr  = '0;
        stk_wdata  = '0;
        stk_raddr  = r_k;

        unique case (r_state)
            S_CLEAR: begin
                cap_we = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                cap_raddr = addr_of(NB'(i_from_node), NB'(i_to_node));
                if (i_valid) begin
                    case (i_operation)
                        OP_CLEAR: begin
                            n_addr  = '0;
                            n_state = S_CLEAR;
                        end
                        OP_ADD: begin
                            if (in_range) begin
                                n_addr   = addr_of(NB'(i_from_node), NB'(i_to_node));
                                n_amount = i_amount;
                                n_state  = S_ADD;
                            end
                        end
                        OP_RUN: begin
                            n_flow  = '0;
                            n_i     = '0;
                            n_state = S_SWEEP;
                        end
                        default: ;
                    endcase
                end
            end
            S_ADD: begin
                cap_we    = 1'b1;
                cap_wdata = (add_sum > SW'(CAP_MAX)) ? CAP_MAX : CAP_BITS'(add_sum);
                n_state   = S_IDLE;
            end
            // phase start: unlevel the nodes up to the sink, level the source, rewind arcs, seed the queue
            S_SWEEP: begin
                node_we.level = 1'b1;
                node_we.arc   = 1'b1;
                node_waddr    = r_i;
                if (r_i == '0) begin
                    lvl_wdata     = {1'b1, {NB{1'b0}}};
                    node_we.queue = 1'b1;
                    q_waddr       = '0;
                    n_head        = '0;
                    n_tail        = (NB+1)'(1);
                    n_found       = 1'b0;
                end
                if (r_i == sink) begin
                    n_state = S_B_POP;
                end else begin
                    n_i = r_i + NB'(1);
                end
            end
            S_B_POP: begin
                if (r_head == r_tail) begin
                    n_state = r_found ? S_D_START : S_FINISH;
                end else begin
                    n_head  = r_head + (NB+1)'(1);
                    n_state = S_B_NODE;
                end
            end
            S_B_NODE: begin
                n_u     = q_rdata[2*NB-1:NB];
                n_lu    = q_rdata[NB-1:0];
                n_i     = '0;
                n_state = S_B_RD;
            end
            S_B_RD: begin
                cap_raddr = addr_of(r_u, r_i);
                n_state   = S_B_EV;
            end
            S_B_EV: begin
                if (!lvl_rdata[NB] && (cap_rdata != '0)) begin
                    node_we.level = 1'b1;
                    node_waddr    = r_i;
                    lvl_wdata     = {1'b1, r_lu + NB'(1)};
                    node_we.queue = 1'b1;
                    q_wdata       = {r_i, r_lu + NB'(1)};
                    n_tail        = r_tail + (NB+1)'(1);
                    if (r_i == sink) begin
                        n_found = 1'b1;
                    end
                end
                if (r_i == sink) begin
                    n_state = S_B_POP;
                end else begin
                    n_i     = r_i + NB'(1);
                    n_state = S_B_RD;
                end
            end
            // new walk from the source
            S_D_START: begin
                n_x           = '0;
                n_d           = '0;
                n_low         = CAP_MAX;
                node_we.stack = 1'b1;
                stk_waddr     = '0;
                stk_wdata     = {{NB{1'b0}}, CAP_MAX};
                arc_raddr     = '0;
                n_state       = S_D_ARC;
            end
            S_D_ARC: begin
                n_arc   = arc_rdata;
                n_state = S_D_RD;
            end
            S_D_RD: begin
                if (r_arc > {1'b0, sink}) begin
                    // dead end: drop the node from the level graph
                    node_we.level = 1'b1;
                    node_waddr    = r_x;
                    if (r_d == '0) begin
                        n_i     = '0;
                        n_state = S_SWEEP;
                    end else begin
                        stk_raddr = r_d - NB'(1);
                        n_d       = r_d - NB'(1);
                        n_state   = S_P_STK;
                    end
                end else begin
                    cap_raddr = addr_of(r_x, NB'(r_arc));
                    lvl_raddr = NB'(r_arc);
                    n_state   = S_D_EV;
                end
            end
            S_D_EV: begin
                if ((cap_rdata != '0) && lvl_rdata[NB] &&
                    ({1'b0, lvl_rdata[NB-1:0]} == ({1'b0, r_d} + (NB+1)'(1)))) begin
                    node_we.arc   = 1'b1;
                    node_waddr    = r_x;
                    arc_wdata     = r_arc;
                    node_we.stack = 1'b1;
                    stk_waddr     = r_d + NB'(1);
                    stk_wdata     = {NB'(r_arc), new_low};
                    if (NB'(r_arc) == sink) begin
                        n_got   = new_low;
                        n_child = sink;
                        n_k     = r_d;
                        n_state = S_U_STK;
                    end else begin
                        n_x       = NB'(r_arc);
                        n_d       = r_d + NB'(1);
                        n_low     = new_low;
                        arc_raddr = NB'(r_arc);
                        n_state   = S_D_ARC;
                    end
                end else begin
                    n_arc   = r_arc + (NB+1)'(1);
                    n_state = S_D_RD;
                end
            end
            // retreat to the parent and move past the failed child
            S_P_STK: begin
                n_x       = stk_node;
                n_low     = stk_low;
                arc_raddr = stk_node;
                n_state   = S_P_ARC;
            end
            S_P_ARC: begin
                n_arc   = arc_rdata + (NB+1)'(1);
                n_state = S_D_RD;
            end
            // push the bottleneck back along the path, sink side first
            S_U_STK: begin
                n_state = S_U_NODE;
            end
            S_U_NODE: begin
                n_x       = stk_node;
                cap_raddr = addr_of(stk_node, r_child);
                n_state   = S_U_FWD;
            end
            S_U_FWD: begin
                cap_we    = 1'b1;
                cap_waddr = addr_of(r_x, r_child);
                cap_wdata = cap_rdata - r_got;
                cap_raddr = addr_of(r_child, r_x);
                n_state   = S_U_REV;
            end
            S_U_REV: begin
                cap_we    = 1'b1;
                cap_waddr = addr_of(r_child, r_x);
                cap_wdata = (rev_sum > SW'(CAP_MAX)) ? CAP_MAX : CAP_BITS'(rev_sum);
                if (r_k == '0) begin
                    n_flow  = (flow_sum > FW'(FLOW_MAX)) ? FLOW_MAX : FLOW_W'(flow_sum);
                    n_state = S_D_START;
                end else begin
                    n_child = r_x;
                    n_k     = r_k - NB'(1);
                    n_state = S_U_STK;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register
    assign n_out_valid = (r_out_valid && !i_ready) || load_out;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
            r_inner     <= INNER_RESET;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_inner <= i_cfg_wdata;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_amount <= n_amount;
        r_i      <= n_i;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_u      <= n_u;
        r_lu     <= n_lu;
        r_found  <= n_found;
        r_x      <= n_x;
        r_d      <= n_d;
        r_low    <= n_low;
        r_arc    <= n_arc;
        r_got    <= n_got;
        r_k      <= n_k;
        r_child  <= n_child;
        r_flow   <= n_flow;
        if (load_out) begin
            r_out_flow <= r_flow;
        end
    end

    // walk depth stays below the sink node number
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_D_EV) |-> (r_d < sink))
        else $error("walk depth reached sink");

    // bfs queue never holds more than the nodes up to the sink
    a_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_B_POP) |-> (r_tail <= ({1'b0, sink} + (NB+1)'(1))))
        else $error("bfs queue overrun");

    // a pushed path always carries flow
    a_got: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_U_STK) |-> (r_got != '0))
        else $error("empty path pushed");

    // results appear only at the end of a run
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINISH))
        else $error("result without finished run");

endmodule
